[design/pst_pkg.sv]
`timescale 1ns / 1ps
package pst_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_W = 15;
  localparam int ANGLE_W = 16;
  localparam int Z_W = 19;

  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  localparam logic signed [Z_W-1:0] HALF_TURN = 19'sd65536;
  localparam logic signed [Z_W-1:0] ANGLE_LIMIT = 19'sd16384;
  localparam logic signed [Z_W-1:0] ANGLE_ROUND = 19'sd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROTATE,
    ST_SCALE,
    ST_RADIUS,
    ST_SUM,
    ST_MAG,
    ST_MAXUP,
    ST_PUBLISH
  } pst_state_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic rotate;
    logic scale;
    logic radius;
    logic sum;
    logic magn;
    logic maxup;
    logic publish;
  } pst_cmd_t;

  typedef struct packed {
    logic hold;
    logic last_step;
  } pst_status_t;

  // atan(2^-i) in counts of 65536 per pi
  function automatic logic [ATAN_W-1:0] atan_count(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 15'd16384;
      5'd1:    val = 15'd9672;
      5'd2:    val = 15'd5110;
      5'd3:    val = 15'd2594;
      5'd4:    val = 15'd1302;
      5'd5:    val = 15'd652;
      5'd6:    val = 15'd326;
      5'd7:    val = 15'd163;
      5'd8:    val = 15'd81;
      5'd9:    val = 15'd41;
      5'd10:   val = 15'd20;
      5'd11:   val = 15'd10;
      5'd12:   val = 15'd5;
      5'd13:   val = 15'd3;
      5'd14:   val = 15'd1;
      5'd15:   val = 15'd1;
      default: val = 15'd0;
    endcase
    return val;
  endfunction

endpackage

[design/pst_item_if.sv]
`timescale 1ns / 1ps
interface pst_item_if #(
  parameter int STRESS_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [STRESS_WIDTH-1:0] stress_x;
  logic signed [STRESS_WIDTH-1:0] stress_y;
  logic signed [STRESS_WIDTH-1:0] shear;
  logic                           second_half;
  logic                           restart;

  modport source (
    output valid, stress_x, stress_y, shear, second_half, restart,
    input  ready
  );

  modport sink (
    input  valid, stress_x, stress_y, shear, second_half, restart,
    output ready
  );
endinterface

[design/pst_result_if.sv]
`timescale 1ns / 1ps
interface pst_result_if #(
  parameter int STRESS_WIDTH = 32
);
  logic                                  valid;
  logic                                  ready;
  logic signed [STRESS_WIDTH-1:0]        principal_major;
  logic signed [STRESS_WIDTH-1:0]        principal_minor;
  logic signed [pst_pkg::ANGLE_W-1:0]    angle;
  logic        [STRESS_WIDTH-2:0]        peak_magnitude;
  logic        [STRESS_WIDTH-2:0]        peak_tension;
  logic        [STRESS_WIDTH-2:0]        peak_compression;

  modport source (
    output valid, principal_major, principal_minor, angle,
           peak_magnitude, peak_tension, peak_compression,
    input  ready
  );

  modport sink (
    input  valid, principal_major, principal_minor, angle,
           peak_magnitude, peak_tension, peak_compression,
    output ready
  );
endinterface

[design/pst_ctrl.sv]
`timescale 1ns / 1ps
module pst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pst_pkg::pst_status_t status,
  output pst_pkg::pst_cmd_t    cmd
);

  pst_pkg::pst_state_t state;
  pst_pkg::pst_state_t state_next;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pst_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      pst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!status.hold) begin
            state_next = pst_pkg::ST_PREP;
          end
        end
      end
      pst_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = pst_pkg::ST_ROTATE;
      end
      pst_pkg::ST_ROTATE: begin
        cmd.rotate = 1'b1;
        if (status.last_step) begin
          state_next = pst_pkg::ST_SCALE;
        end
      end
      pst_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = pst_pkg::ST_RADIUS;
      end
      pst_pkg::ST_RADIUS: begin
        cmd.radius = 1'b1;
        state_next = pst_pkg::ST_SUM;
      end
      pst_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = pst_pkg::ST_MAG;
      end
      pst_pkg::ST_MAG: begin
        cmd.magn   = 1'b1;
        state_next = pst_pkg::ST_MAXUP;
      end
      pst_pkg::ST_MAXUP: begin
        cmd.maxup  = 1'b1;
        state_next = pst_pkg::ST_PUBLISH;
      end
      pst_pkg::ST_PUBLISH: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = pst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pst_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

`ifndef SYNTHESIS
  a_work_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !status.hold) |=> (state == pst_pkg::ST_PREP))
    else $error("accepted request did not start processing");

  a_hold_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && status.hold) |=> in_ready)
    else $error("held request left the controller busy");

  a_result_from_publish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == pst_pkg::ST_PUBLISH))
    else $error("result valid raised outside publish");
`endif

endmodule

[design/pst_datapath.sv]
`timescale 1ns / 1ps
module pst_datapath #(
  parameter int STRESS_WIDTH = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pst_pkg::pst_cmd_t                 cmd,
  output pst_pkg::pst_status_t              status,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  input  logic signed [STRESS_WIDTH-1:0]    stress_x,
  input  logic signed [STRESS_WIDTH-1:0]    stress_y,
  input  logic signed [STRESS_WIDTH-1:0]    shear,
  input  logic                              second_half,
  input  logic                              restart,
  output logic signed [STRESS_WIDTH-1:0]    principal_major,
  output logic signed [STRESS_WIDTH-1:0]    principal_minor,
  output logic signed [pst_pkg::ANGLE_W-1:0] angle,
  output logic        [STRESS_WIDTH-2:0]    peak_magnitude,
  output logic        [STRESS_WIDTH-2:0]    peak_tension,
  output logic        [STRESS_WIDTH-2:0]    peak_compression
);

  localparam int W = STRESS_WIDTH;
  localparam int GUARD = (48 - W) / 2 + 8;
  localparam int RAD_Q = ((58 - W) < 30) ? (58 - W) : 30;
  localparam int CW = W + GUARD + 3;
  localparam int XSW = CW - GUARD;
  localparam int PW = XSW + RAD_Q;
  localparam int RW = PW - RAD_Q;
  localparam int EW = W + 4;
  localparam int ZW = pst_pkg::Z_W;
  localparam int ROT_STEPS = (CORDIC_STEPS < pst_pkg::ATAN_ENTRIES) ?
                             CORDIC_STEPS : pst_pkg::ATAN_ENTRIES;
  localparam int SW = (ROT_STEPS > 1) ? $clog2(ROT_STEPS) : 1;
  localparam logic [RAD_Q-1:0] KGAIN = RAD_Q'(pst_pkg::INV_GAIN_Q30 >> (30 - RAD_Q));
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

  function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] v);
    logic [EW-W:0] top;
    top = v[EW-1:W-1];
    if (top != '0 && top != '1) begin
      return v[EW-1] ? SMIN : SMAX;
    end
    return v[W-1:0];
  endfunction

  function automatic logic [W-2:0] mag_w(input logic signed [W-1:0] v);
    logic signed [W-1:0] negv;
    negv = -v;
    if (v == SMIN) begin
      return '1;
    end
    return v[W-1] ? negv[W-2:0] : v[W-2:0];
  endfunction

  logic                   average_mode;
  logic                   held_valid;
  logic signed [W-1:0]    held_stress_x;
  logic signed [W-1:0]    held_stress_y;
  logic signed [W-1:0]    held_shear;
  logic signed [W-1:0]    op_x;
  logic signed [W-1:0]    op_y;
  logic signed [W-1:0]    op_tau;
  logic signed [W-1:0]    mean;
  logic                   neg_d;
  logic                   tau_neg;
  logic                   zero_case;
  logic signed [CW-1:0]   cx;
  logic signed [CW-1:0]   cy;
  logic signed [ZW-1:0]   cz;
  logic [SW-1:0]          step;
  logic [PW-1:0]          prod;
  logic signed [ZW-1:0]   ang;
  logic [RW-1:0]          radius;
  logic signed [W-1:0]    major;
  logic signed [W-1:0]    minor;
  logic [W-2:0]           mag_major;
  logic [W-2:0]           mag_minor;
  logic                   major_pos;
  logic                   major_neg;
  logic                   minor_pos;
  logic                   minor_neg;
  logic [W-2:0]           max_magnitude;
  logic [W-2:0]           max_tension;
  logic [W-2:0]           max_compression;

  // averaging of the held triangle
  logic signed [W:0]      sum_ax;
  logic signed [W:0]      sum_ay;
  logic signed [W:0]      sum_at;
  logic                   use_avg;

  assign sum_ax  = {stress_x[W-1], stress_x} + {held_stress_x[W-1], held_stress_x};
  assign sum_ay  = {stress_y[W-1], stress_y} + {held_stress_y[W-1], held_stress_y};
  assign sum_at  = {shear[W-1], shear} + {held_shear[W-1], held_shear};
  assign use_avg = average_mode && held_valid;

  assign status.hold      = average_mode && !second_half;
  assign status.last_step = (step == SW'(ROT_STEPS - 1));

  // setup
  logic signed [W:0]      sum_xy;
  logic signed [W:0]      diff;
  logic signed [W:0]      ndiff;
  logic signed [W+1:0]    two_tau;
  logic signed [W+1:0]    neg_two_tau;
  logic                   d_neg;

  assign sum_xy      = {op_x[W-1], op_x} + {op_y[W-1], op_y};
  assign diff        = {op_x[W-1], op_x} - {op_y[W-1], op_y};
  assign ndiff       = {op_y[W-1], op_y} - {op_x[W-1], op_x};
  assign two_tau     = {op_tau[W-1], op_tau, 1'b0};
  assign neg_two_tau = -two_tau;
  assign d_neg       = diff[W];

  // cordic vectoring step
  logic signed [CW-1:0]   shx;
  logic signed [CW-1:0]   shy;
  logic signed [ZW-1:0]   atan_z;
  logic                   y_nonneg;

  assign shx      = cx >>> step;
  assign shy      = cy >>> step;
  assign atan_z   = signed'(ZW'(pst_pkg::atan_count(pst_pkg::ATAN_IDX_W'(step))));
  assign y_nonneg = !cy[CW-1];

  // gain removal and angle
  logic [XSW-1:0]         xs;
  logic signed [ZW-1:0]   base_val;
  logic signed [ZW-1:0]   ang_sum;
  logic signed [ZW-1:0]   ang_q;
  logic [PW:0]            rsum;

  assign xs       = cx[CW-1:GUARD];
  assign base_val = neg_d ? (tau_neg ? -pst_pkg::HALF_TURN : pst_pkg::HALF_TURN) : '0;
  assign ang_sum  = cz + base_val + pst_pkg::ANGLE_ROUND;
  assign ang_q    = ang_sum >>> 2;
  assign rsum     = {1'b0, prod} + ((PW+1)'(1) << RAD_Q);

  // principal values
  logic signed [EW-1:0]   mean_e;
  logic signed [EW-1:0]   rad_e;
  logic signed [EW-1:0]   major_full;
  logic signed [EW-1:0]   minor_full;

  assign mean_e     = EW'(mean);
  assign rad_e      = signed'(EW'(radius));
  assign major_full = mean_e + rad_e;
  assign minor_full = mean_e - rad_e;

  // running maxima, major first then minor
  logic [W-2:0]           mm1;
  logic [W-2:0]           mm_next;
  logic [W-2:0]           mt1;
  logic [W-2:0]           mt_next;
  logic [W-2:0]           mc1;
  logic [W-2:0]           mc_next;

  assign mm1     = (mag_major > max_magnitude) ? mag_major : max_magnitude;
  assign mm_next = (mag_minor > mm1) ? mag_minor : mm1;
  assign mt1     = (major_pos && mag_major > max_tension) ? mag_major : max_tension;
  assign mt_next = (minor_pos && mag_minor > mt1) ? mag_minor : mt1;
  assign mc1     = (major_neg && mag_major > max_compression) ? mag_major : max_compression;
  assign mc_next = (minor_neg && mag_minor > mc1) ? mag_minor : mc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_mode    <= 1'b0;
      held_valid      <= 1'b0;
      max_magnitude   <= '0;
      max_tension     <= '0;
      max_compression <= '0;
    end else begin
      if (cfg_wr_en) begin
        average_mode <= cfg_wr_data;
      end
      if (cmd.accept) begin
        if (status.hold) begin
          held_valid <= 1'b1;
        end else if (use_avg) begin
          held_valid <= 1'b0;
        end
        if (restart) begin
          max_magnitude   <= '0;
          max_tension     <= '0;
          max_compression <= '0;
        end
      end
      if (cmd.maxup) begin
        max_magnitude   <= mm_next;
        max_tension     <= mt_next;
        max_compression <= mc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (status.hold) begin
        held_stress_x <= stress_x;
        held_stress_y <= stress_y;
        held_shear    <= shear;
      end else if (use_avg) begin
        op_x   <= sum_ax[W:1];
        op_y   <= sum_ay[W:1];
        op_tau <= sum_at[W:1];
      end else begin
        op_x   <= stress_x;
        op_y   <= stress_y;
        op_tau <= shear;
      end
    end
    if (cmd.prep) begin
      mean      <= sum_xy[W:1];
      neg_d     <= d_neg;
      tau_neg   <= op_tau[W-1];
      zero_case <= (diff == '0) && (op_tau == '0);
      cx        <= CW'(d_neg ? ndiff : diff) <<< GUARD;
      cy        <= CW'(d_neg ? neg_two_tau : two_tau) <<< GUARD;
      cz        <= '0;
      step      <= '0;
    end
    if (cmd.rotate) begin
      if (y_nonneg) begin
        cx <= cx + shy;
        cy <= cy - shx;
        cz <= cz + atan_z;
      end else begin
        cx <= cx - shy;
        cy <= cy + shx;
        cz <= cz - atan_z;
      end
      step <= step + 1'b1;
    end
    if (cmd.scale) begin
      prod <= xs * KGAIN;
      if (zero_case) begin
        ang <= '0;
      end else if (ang_q > pst_pkg::ANGLE_LIMIT) begin
        ang <= pst_pkg::ANGLE_LIMIT;
      end else if (ang_q < -pst_pkg::ANGLE_LIMIT) begin
        ang <= -pst_pkg::ANGLE_LIMIT;
      end else begin
        ang <= ang_q;
      end
    end
    if (cmd.radius) begin
      radius <= zero_case ? '0 : rsum[PW:RAD_Q+1];
    end
    if (cmd.sum) begin
      major <= sat_w(major_full);
      minor <= sat_w(minor_full);
    end
    if (cmd.magn) begin
      mag_major <= mag_w(major);
      mag_minor <= mag_w(minor);
      major_pos <= !major[W-1] && (major != '0);
      major_neg <= major[W-1];
      minor_pos <= !minor[W-1] && (minor != '0);
      minor_neg <= minor[W-1];
    end
    if (cmd.publish) begin
      principal_major  <= major;
      principal_minor  <= minor;
      angle            <= ang[pst_pkg::ANGLE_W-1:0];
      peak_magnitude   <= max_magnitude;
      peak_tension     <= max_tension;
      peak_compression <= max_compression;
    end
  end

endmodule

[design/principal_stress_tracker.sv]
`timescale 1ns / 1ps
// Plane stress to principal stresses: each request (stress_x, stress_y, shear) yields
// major = mean + R and minor = mean - R, saturated to STRESS_WIDTH bits, and the principal
// angle at 32768 counts per pi, with R and the angle taken from one shared CORDIC vectoring
// unit that runs one step per cycle. The result also carries the running peaks of
// magnitude, tension and compression; restart clears them before its request is used.
// With average_mode set, a first-half request is only held (no result) and the following
// second-half request yields one result for the mean of both triangles. A request that
// produces a result passes through the setup, CORDIC iteration, multiply, rounding,
// saturation, magnitude and peak-update states before the next request can be accepted;
// a held request leaves the controller idle and ready for another request.
// The finished result sits in an output register, so with a stalled sink one more request
// is still accepted and processed; its result then waits in the publish state and no
// request is accepted until the output register drains.
module principal_stress_tracker #(
  parameter int CORDIC_STEPS = 16,
  parameter int STRESS_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  pst_item_if.sink     items,
  pst_result_if.source results
);

  pst_pkg::pst_cmd_t    cmd;
  pst_pkg::pst_status_t status;

  pst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pst_datapath #(
    .STRESS_WIDTH (STRESS_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .stress_x         (items.stress_x),
    .stress_y         (items.stress_y),
    .shear            (items.shear),
    .second_half      (items.second_half),
    .restart          (items.restart),
    .principal_major  (results.principal_major),
    .principal_minor  (results.principal_minor),
    .angle            (results.angle),
    .peak_magnitude   (results.peak_magnitude),
    .peak_tension     (results.peak_tension),
    .peak_compression (results.peak_compression)
  );

endmodule
